// File: design/form_urlencoded_decoder_defines.svh
// assertion macros shared by the form decoder checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef FORM_URLENCODED_DECODER_DEFINES_SVH
`define FORM_URLENCODED_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FUD_ASSERT_IMPLY(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FUD_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`endif

// File: design/fud_pkg.sv
// types, character codes and hex helper for the form decoder
// no dependencies
package fud_pkg;

    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [3:0] {
        PH_NAME  = 4'b0001,
        PH_VALUE = 4'b0010,
        PH_HEX1  = 4'b0100,
        PH_HEX2  = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NAME_LONG  = 3'd1,
        ST_VALUE_LONG = 3'd2,
        ST_SYNTAX     = 3'd3,
        ST_NO_EQUALS  = 3'd4
    } status_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] high_nibble;
        logic       halted;
    } ctl_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       is_value;
        logic       pair_end;
        status_t    status;
        logic       form_done;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] nibble;
    } hex_t;

    localparam ctl_t CTL_RESET = '{phase: PH_NAME, high_nibble: 4'd0, halted: 1'b0};

    // ascii hex digit, either case
    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok     = 1'b0;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.ok     = 1'b1;
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            h.ok     = 1'b1;
            h.nibble = c[3:0] + 4'd9;
        end
        return h;
    endfunction

endpackage

// File: design/fud_decode.sv
// per-byte decode: next parser state and the result for one byte
// depends on fud_pkg
module fud_decode
    import fud_pkg::*;
#(
    parameter int NAME_LIMIT  = 64,
    parameter int VALUE_LIMIT = 4096,
    localparam int NW = $clog2(NAME_LIMIT),
    localparam int VW = $clog2(VALUE_LIMIT)
)
(
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  ctl_t          ctl,
    input  logic [NW-1:0] name_count,
    input  logic [VW-1:0] value_count,
    output ctl_t          ctl_next,
    output logic [NW-1:0] name_count_next,
    output logic [VW-1:0] value_count_next,
    output result_t       result
);

    localparam logic [NW-1:0] NAME_MAX  = NW'(NAME_LIMIT - 1);
    localparam logic [VW-1:0] VALUE_MAX = VW'(VALUE_LIMIT - 1);

    hex_t       hex;
    logic [7:0] vbyte;
    logic       have_vbyte;

    always_comb
    begin
        hex              = hex_decode(data_byte);
        vbyte            = 8'd0;
        have_vbyte       = 1'b0;
        ctl_next         = ctl;
        name_count_next  = name_count;
        value_count_next = value_count;
        result           = '{out_byte: 8'd0, byte_valid: 1'b0, is_value: 1'b0,
                             pair_end: 1'b0, status: ST_OK, form_done: last_byte};

        if (!ctl.halted)
        begin
            unique case (ctl.phase)
                PH_NAME:
                begin
                    if (data_byte == CH_EQUALS)
                    begin
                        ctl_next.phase   = PH_VALUE;
                        value_count_next = '0;
                        result.pair_end  = last_byte;
                    end
                    else if (name_count >= NAME_MAX)
                        result.status = ST_NAME_LONG;
                    else if (last_byte)
                        result.status = ST_NO_EQUALS;
                    else
                    begin
                        result.out_byte   = data_byte;
                        result.byte_valid = 1'b1;
                        name_count_next   = name_count + NW'(1);
                    end
                end
                PH_VALUE:
                begin
                    if (data_byte == CH_AMP)
                    begin
                        result.pair_end  = 1'b1;
                        ctl_next.phase   = PH_NAME;
                        name_count_next  = '0;
                        value_count_next = '0;
                    end
                    else if (data_byte == CH_PERCENT)
                    begin
                        if (last_byte)
                            result.status = ST_SYNTAX;
                        else
                            ctl_next.phase = PH_HEX1;
                    end
                    else
                    begin
                        vbyte      = (data_byte == CH_PLUS) ? CH_SPACE : data_byte;
                        have_vbyte = 1'b1;
                    end
                end
                PH_HEX1:
                begin
                    if (!hex.ok || last_byte)
                        result.status = ST_SYNTAX;
                    else
                    begin
                        ctl_next.high_nibble = hex.nibble;
                        ctl_next.phase       = PH_HEX2;
                    end
                end
                PH_HEX2:
                begin
                    if (!hex.ok)
                        result.status = ST_SYNTAX;
                    else
                    begin
                        vbyte          = {ctl.high_nibble, hex.nibble};
                        have_vbyte     = 1'b1;
                        ctl_next.phase = PH_VALUE;
                    end
                end
                default:
                begin
                    ctl_next = CTL_RESET;
                end
            endcase

            if (have_vbyte)
            begin
                if (value_count >= VALUE_MAX)
                    result.status = ST_VALUE_LONG;
                else
                begin
                    result.out_byte   = vbyte;
                    result.byte_valid = 1'b1;
                    result.is_value   = 1'b1;
                    result.pair_end   = last_byte;
                    value_count_next  = value_count + VW'(1);
                end
            end

            if (result.status != ST_OK)
                ctl_next.halted = 1'b1;
        end

        // the last byte closes the form string whatever came before
        if (last_byte)
        begin
            ctl_next         = CTL_RESET;
            name_count_next  = '0;
            value_count_next = '0;
        end
    end

endmodule

// File: design/form_urlencoded_decoder.sv
// form_urlencoded_decoder: streaming decoder for url-encoded form data
// depends on fud_pkg and fud_decode
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   in      | sink      | in_valid / in_ready  | data_byte, last_byte
//   out     | source    | out_valid / out_ready| out_byte, byte_valid, is_value,
//           |           |                      | pair_end, status, form_done
//
// one beat in gives exactly one beat out, via the input then the result register
// sustained rate is one beat per cycle when out is not stalled; the two registers
// form a two-stage pipe, with the parser state updated as a beat moves between them
// rst_n clears both stage valids and the parser state (name phase, counts zero)
// a stall on out holds the result register and the input register in place,
// so in_ready falls only when both stages are full and out_ready is low
module form_urlencoded_decoder
    import fud_pkg::*;
#(
    parameter int NAME_LIMIT  = 64,
    parameter int VALUE_LIMIT = 4096
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       is_value,
    output logic       pair_end,
    output logic [2:0] status,
    output logic       form_done
);

    localparam int NW = $clog2(NAME_LIMIT);
    localparam int VW = $clog2(VALUE_LIMIT);

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    ctl_t          ctl_reg;
    ctl_t          ctl_next;
    logic [NW-1:0] name_count_reg;
    logic [NW-1:0] name_count_next;
    logic [VW-1:0] value_count_reg;
    logic [VW-1:0] value_count_next;

    // result stage
    logic    out_valid_reg;
    result_t result_reg;
    result_t result_next;

    logic advance;

    // the result stage can take a new beat when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    fud_decode #(
        .NAME_LIMIT  (NAME_LIMIT),
        .VALUE_LIMIT (VALUE_LIMIT)
    ) u_decode (
        .data_byte        (in_byte_reg),
        .last_byte        (in_last_reg),
        .ctl              (ctl_reg),
        .name_count       (name_count_reg),
        .value_count      (value_count_reg),
        .ctl_next         (ctl_next),
        .name_count_next  (name_count_next),
        .value_count_next (value_count_next),
        .result           (result_next)
    );

    // control: stage valids and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            ctl_reg         <= CTL_RESET;
            name_count_reg  <= '0;
            value_count_reg <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            // state moves only when a beat leaves the input stage
            if (in_valid_reg && advance)
            begin
                ctl_reg         <= ctl_next;
                name_count_reg  <= name_count_next;
                value_count_reg <= value_count_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (in_valid_reg && advance)
            result_reg <= result_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = result_reg.out_byte;
    assign byte_valid = result_reg.byte_valid;
    assign is_value   = result_reg.is_value;
    assign pair_end   = result_reg.pair_end;
    assign status     = result_reg.status;
    assign form_done  = result_reg.form_done;

endmodule

// File: design/fud_checker.sv
// port-level checks for form_urlencoded_decoder, bound to the top level
// depends on form_urlencoded_decoder_defines.svh and fud_pkg
`include "form_urlencoded_decoder_defines.svh"

module fud_checker
    import fud_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] data_byte,
    input logic       last_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       is_value,
    input logic       pair_end,
    input logic [2:0] status,
    input logic       form_done
);

    // a beat that carries no byte shows zero byte and name tag
    `FUD_ASSERT_IMPLY(a_empty_beat_zero, out_valid && !byte_valid,
        out_byte == 8'd0 && !is_value, "empty beat carries data")

    // an error beat neither emits a byte nor ends a pair
    `FUD_ASSERT_IMPLY(a_error_silent, out_valid && status != ST_OK,
        !byte_valid && !pair_end, "error beat emits byte or pair end")

    // a byte that ends a pair must be a value byte
    `FUD_ASSERT_IMPLY(a_pair_end_value, out_valid && pair_end && byte_valid,
        is_value, "pair ends on a name byte")

    // a stalled result beat holds
    `FUD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(status) && $stable(pair_end)
        && $stable(form_done), "stalled result beat changed")

endmodule

bind form_urlencoded_decoder fud_checker u_fud_checker (.*);
